### hdl/pplm_pkg.sv
// Shared constants and types for the particle pool lifetime manager.
// Used by pplm_ctrl, pplm_dp and the top level; no dependencies.
package pplm_pkg;

    localparam int POOL_SIZE = 4096;
    localparam int IDX_W     = $clog2(POOL_SIZE);
    localparam int LINK_W    = $clog2(POOL_SIZE + 1);
    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(POOL_SIZE);

    localparam int SLOT_W  = 12;
    localparam int CNT_W   = 13;
    localparam int ALPHA_W = 8;
    localparam int LIFE_W  = 16;
    localparam int FADE_W  = 8;

    localparam int DIV_STEPS = FADE_W;
    localparam int DIVC_W    = $clog2(DIV_STEPS);

    localparam logic FUNC_SPAWN = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    typedef struct packed {
        logic [ALPHA_W-1:0] alpha;
        logic [FADE_W-1:0]  fade;
        logic [LIFE_W-1:0]  ticks;
    } slot_rec_t;

    // controller -> datapath
    typedef struct packed {
        logic load_in;
        logic clr_step;
        logic sp_read;
        logic div_step;
        logic sp_commit;
        logic tk_start;
        logic tk_walk;
        logic tk_fix;
        logic out_load;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic free_empty;
        logic active_empty;
        logic div_last;
        logic walk_last;
        logic walk_fix;
    } dp_stat_t;

endpackage

### hdl/pplm_ctrl.sv
// Sequencer for the particle pool: clearing pass, spawn, tick walk, result handoff.
// Depends on pplm_pkg; drives pplm_dp through dp_cmd_t.
module pplm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic               func,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output pplm_pkg::dp_cmd_t  cmd,
    input  pplm_pkg::dp_stat_t stat
);
    import pplm_pkg::*;

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_SPAWN  = 9'b000000100,
        S_DIV    = 9'b000001000,
        S_COMMIT = 9'b000010000,
        S_TSTART = 9'b000100000,
        S_WALK   = 9'b001000000,
        S_FIX    = 9'b010000000,
        S_DONE   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = (func == FUNC_TICK) ? S_TSTART : S_SPAWN;
                end
            end
            S_SPAWN:
            begin
                cmd.sp_read = 1'b1;
                state_next  = stat.free_empty ? S_DONE : S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                cmd.sp_commit = 1'b1;
                state_next    = S_DONE;
            end
            S_TSTART:
            begin
                cmd.tk_start = 1'b1;
                state_next   = stat.active_empty ? S_DONE : S_WALK;
            end
            S_WALK:
            begin
                cmd.tk_walk = 1'b1;
                if (stat.walk_last)
                begin
                    state_next = stat.walk_fix ? S_FIX : S_DONE;
                end
            end
            S_FIX:
            begin
                cmd.tk_fix = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase

        if (cmd.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

### hdl/pplm_dp.sv
// Datapath for the particle pool: link and particle memories, list heads,
// fade divider, walk registers and result registers. Depends on pplm_pkg.
module pplm_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pplm_pkg::dp_cmd_t             cmd,
    output pplm_pkg::dp_stat_t            stat,
    input  logic                          func,
    input  logic [pplm_pkg::ALPHA_W-1:0]  start_alpha,
    input  logic [pplm_pkg::LIFE_W-1:0]   lifetime,
    input  logic                          fade_auto,
    input  logic [pplm_pkg::FADE_W-1:0]   fade_step,
    output logic                          granted,
    output logic [pplm_pkg::SLOT_W-1:0]   slot,
    output logic [pplm_pkg::CNT_W-1:0]    freed_count,
    output logic [pplm_pkg::CNT_W-1:0]    active_count
);
    import pplm_pkg::*;

    logic [LINK_W-1:0] link_mem [POOL_SIZE];
    slot_rec_t         part_mem [POOL_SIZE];

    // latched request
    logic               func_reg;
    logic [ALPHA_W-1:0] alpha_reg;
    logic [LIFE_W-1:0]  life_reg;
    logic               fauto_reg;
    logic [FADE_W-1:0]  fstep_reg;

    // list state
    logic [IDX_W-1:0]  clr_idx_reg;
    logic [LINK_W-1:0] free_head_reg;
    logic [LINK_W-1:0] active_head_reg;
    logic [LINK_W-1:0] live_reg;

    // walk state
    logic [IDX_W-1:0]  cur_reg;
    logic [IDX_W-1:0]  prev_reg;
    logic              prev_valid_reg;
    logic              pending_reg;
    logic [LINK_W-1:0] freed_reg;

    // fade divider
    logic [FADE_W-1:0] rem_reg;
    logic [FADE_W-1:0] quo_reg;
    logic [DIVC_W-1:0] div_cnt_reg;
    logic [FADE_W-1:0] dvs;
    logic [FADE_W:0]   trial;
    logic              ge;
    logic [FADE_W-1:0] fade_val;

    logic              grant_reg;
    logic [IDX_W-1:0]  slot_idx_reg;

    logic              granted_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [CNT_W-1:0]  freed_out_reg;
    logic [CNT_W-1:0]  active_out_reg;

    // memory read data
    logic [LINK_W-1:0] link_q;
    slot_rec_t         pd_q;

    // memory ports
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              lw_en;
    logic [IDX_W-1:0]  lw_addr;
    logic [LINK_W-1:0] lw_data;
    logic              pw_en;
    logic [IDX_W-1:0]  pw_addr;
    slot_rec_t         pw_data;

    // walk evaluation
    logic [IDX_W-1:0]   nxt_idx;
    logic               nxt_null;
    logic [ALPHA_W-1:0] now_alpha;
    logic [LIFE_W-1:0]  ticks_dec;
    logic               wrap;
    logic               expire;
    logic [IDX_W-1:0]   free_idx;
    logic [IDX_W-1:0]   active_idx;

    assign free_idx   = free_head_reg[IDX_W-1:0];
    assign active_idx = active_head_reg[IDX_W-1:0];

    assign nxt_idx   = link_q[IDX_W-1:0];
    assign nxt_null  = (link_q == LINK_NULL);
    assign now_alpha = pd_q.alpha - pd_q.fade;
    assign wrap      = (pd_q.alpha < now_alpha);
    assign ticks_dec = pd_q.ticks - LIFE_W'(1);
    // a wrap frees the slot whatever the lifetime says
    assign expire    = wrap || (ticks_dec == '0);

    // 255 / d, restoring, one quotient bit per step; dividend is all ones
    assign dvs   = (life_reg[FADE_W-1:0] == '0) ? FADE_W'(1) : life_reg[FADE_W-1:0];
    assign trial = {rem_reg, 1'b1};
    assign ge    = (trial >= {1'b0, dvs});

    always_comb
    begin
        if (!fauto_reg)
        begin
            fade_val = fstep_reg;
        end
        else if (life_reg[LIFE_W-1:FADE_W] != '0)
        begin
            fade_val = '0;
        end
        else
        begin
            fade_val = quo_reg;
        end
    end

    assign stat.clr_last     = (clr_idx_reg == IDX_W'(POOL_SIZE - 1));
    assign stat.free_empty   = (free_head_reg == LINK_NULL);
    assign stat.active_empty = (active_head_reg == LINK_NULL);
    assign stat.div_last     = (div_cnt_reg == DIVC_W'(DIV_STEPS - 1));
    assign stat.walk_last    = nxt_null;
    assign stat.walk_fix     = expire && prev_valid_reg;

    // read port: one address per cycle, shared by both memories
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = nxt_idx;
        unique if (cmd.sp_read)
        begin
            rd_en   = !stat.free_empty;
            rd_addr = free_idx;
        end
        else if (cmd.tk_start)
        begin
            rd_en   = !stat.active_empty;
            rd_addr = active_idx;
        end
        else if (cmd.tk_walk)
        begin
            rd_en   = !nxt_null;
            rd_addr = nxt_idx;
        end
        else
        begin
            rd_en = 1'b0;
        end
    end

    // link write port; a freed slot and the survivor relink never share a cycle
    always_comb
    begin
        lw_en   = 1'b0;
        lw_addr = cur_reg;
        lw_data = free_head_reg;
        unique if (cmd.clr_step)
        begin
            lw_en   = 1'b1;
            lw_addr = clr_idx_reg;
            lw_data = LINK_W'(clr_idx_reg) + LINK_W'(1);
        end
        else if (cmd.sp_commit)
        begin
            lw_en   = 1'b1;
            lw_addr = free_idx;
            lw_data = active_head_reg;
        end
        else if (cmd.tk_walk)
        begin
            if (expire)
            begin
                lw_en   = 1'b1;
                lw_addr = cur_reg;
                lw_data = free_head_reg;
            end
            else if (pending_reg)
            begin
                lw_en   = 1'b1;
                lw_addr = prev_reg;
                lw_data = LINK_W'(cur_reg);
            end
        end
        else if (cmd.tk_fix)
        begin
            lw_en   = 1'b1;
            lw_addr = prev_reg;
            lw_data = LINK_NULL;
        end
        else
        begin
            lw_en = 1'b0;
        end
    end

    always_comb
    begin
        pw_en   = 1'b0;
        pw_addr = cur_reg;
        pw_data = '0;
        unique if (cmd.sp_commit)
        begin
            pw_en         = 1'b1;
            pw_addr       = free_idx;
            pw_data.alpha = alpha_reg;
            pw_data.fade  = fade_val;
            pw_data.ticks = life_reg;
        end
        else if (cmd.tk_walk)
        begin
            pw_en   = 1'b1;
            pw_addr = cur_reg;
            if (!expire)
            begin
                pw_data.alpha = now_alpha;
                pw_data.fade  = pd_q.fade;
                pw_data.ticks = ticks_dec;
            end
        end
        else
        begin
            pw_en = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (lw_en)
        begin
            link_mem[lw_addr] <= lw_data;
        end
        if (rd_en)
        begin
            link_q <= link_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pw_en)
        begin
            part_mem[pw_addr] <= pw_data;
        end
        if (rd_en)
        begin
            pd_q <= part_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg     <= '0;
            free_head_reg   <= '0;
            active_head_reg <= LINK_NULL;
            live_reg        <= '0;
            pending_reg     <= 1'b0;
            prev_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_idx_reg <= clr_idx_reg + IDX_W'(1);
            end
            if (cmd.sp_commit)
            begin
                free_head_reg   <= link_q;
                active_head_reg <= free_head_reg;
                live_reg        <= live_reg + LINK_W'(1);
            end
            if (cmd.tk_start)
            begin
                pending_reg    <= 1'b0;
                prev_valid_reg <= 1'b0;
            end
            if (cmd.tk_walk)
            begin
                if (expire)
                begin
                    free_head_reg <= LINK_W'(cur_reg);
                    if (live_reg != '0)
                    begin
                        live_reg <= live_reg - LINK_W'(1);
                    end
                    // predecessor gets relinked once the next survivor shows up
                    if (prev_valid_reg)
                    begin
                        pending_reg <= 1'b1;
                    end
                    else
                    begin
                        active_head_reg <= link_q;
                    end
                end
                else
                begin
                    pending_reg    <= 1'b0;
                    prev_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            func_reg  <= func;
            alpha_reg <= start_alpha;
            life_reg  <= lifetime;
            fauto_reg <= fade_auto;
            fstep_reg <= fade_step;
            freed_reg <= '0;
        end
        if (cmd.sp_read)
        begin
            grant_reg    <= !stat.free_empty;
            slot_idx_reg <= stat.free_empty ? '0 : free_idx;
            rem_reg      <= '0;
            quo_reg      <= '0;
            div_cnt_reg  <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg     <= ge ? FADE_W'(trial - {1'b0, dvs}) : FADE_W'(trial);
            quo_reg     <= {quo_reg[FADE_W-2:0], ge};
            div_cnt_reg <= div_cnt_reg + DIVC_W'(1);
        end
        if (cmd.tk_start)
        begin
            cur_reg <= active_idx;
        end
        if (cmd.tk_walk)
        begin
            cur_reg <= nxt_idx;
            if (expire)
            begin
                freed_reg <= freed_reg + LINK_W'(1);
            end
            else
            begin
                prev_reg <= cur_reg;
            end
        end
        if (cmd.out_load)
        begin
            if (func_reg == FUNC_TICK)
            begin
                granted_reg   <= 1'b0;
                slot_reg      <= '0;
                freed_out_reg <= CNT_W'(freed_reg);
            end
            else
            begin
                granted_reg   <= grant_reg;
                slot_reg      <= SLOT_W'(slot_idx_reg);
                freed_out_reg <= '0;
            end
            active_out_reg <= CNT_W'(live_reg);
        end
    end

    assign granted      = granted_reg;
    assign slot         = slot_reg;
    assign freed_count  = freed_out_reg;
    assign active_count = active_out_reg;

endmodule

### hdl/particle_pool_lifetime_manager_unit.sv
// Top level of the particle pool lifetime manager.
// Instantiates pplm_ctrl and pplm_dp; depends on pplm_pkg.

// Pool of POOL_SIZE particle slots on a free list and an active list, both
// pushed at the head. After reset the block runs a clearing pass over all
// POOL_SIZE slots that builds the free chain; requests stall until it ends.
// One request is worked at a time. A spawn reads the free head and then runs
// the 8-step fade divider (255 / lifetime) before it commits; a spawn that
// finds the pool empty skips the divider. A tick walks the N live particles
// of the active list, with one fix step after the walk when the last slot
// walked is freed behind a survivor; the walk follows the link memory read
// port, one slot per cycle. A new request is taken while the previous result
// still waits in the output register.
module particle_pool_lifetime_manager_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic                          func,
    input  logic [pplm_pkg::ALPHA_W-1:0]  start_alpha,
    input  logic [pplm_pkg::LIFE_W-1:0]   lifetime,
    input  logic                          fade_auto,
    input  logic [pplm_pkg::FADE_W-1:0]   fade_step,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic                          granted,
    output logic [pplm_pkg::SLOT_W-1:0]   slot,
    output logic [pplm_pkg::CNT_W-1:0]    freed_count,
    output logic [pplm_pkg::CNT_W-1:0]    active_count
);
    import pplm_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    pplm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .func      (func),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    pplm_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .func         (func),
        .start_alpha  (start_alpha),
        .lifetime     (lifetime),
        .fade_auto    (fade_auto),
        .fade_step    (fade_step),
        .granted      (granted),
        .slot         (slot),
        .freed_count  (freed_count),
        .active_count (active_count)
    );

    // one request in flight
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request accepted while another is in progress");

    // a granted spawn leaves at least that particle live
    a_grant_live: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && granted |-> active_count != '0)
        else $error("granted spawn reports no live particles");

    // spawns free nothing
    a_grant_no_free: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && granted |-> freed_count == '0)
        else $error("spawn result reports freed slots");

    // walk step and list relink never collide with a spawn commit
    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clr_step, cmd.sp_commit, cmd.tk_walk, cmd.tk_fix}))
        else $error("conflicting link memory writers");

endmodule

### verif/tb_particle_pool_lifetime_manager_unit.sv
// Testbench for particle_pool_lifetime_manager_unit: directed and random spawn/tick requests,
// checked against an in-bench free/active list predictor.
// Depends on pplm_pkg and the RTL top level only.
module tb_particle_pool_lifetime_manager_unit;
    import pplm_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int WATCHDOG_LIMIT = 30000;
    localparam int DRAIN_CYCLES   = 64;
    localparam int RAND_ITEMS     = 110;
    localparam int TAIL_SPAWNS    = 6;

    typedef struct {
        logic              func;
        logic [ALPHA_W-1:0] alpha;
        logic [LIFE_W-1:0]  life;
        logic              fade_auto;
        logic [FADE_W-1:0]  fade_step;
        bit                drain;
        bit                calm;
    } pool_req_t;

    typedef struct {
        logic              granted;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  freed;
        logic [CNT_W-1:0]  live;
    } pool_rsp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    logic func = FUNC_SPAWN;
    logic [ALPHA_W-1:0] start_alpha = '0;
    logic [LIFE_W-1:0] lifetime = '0;
    logic fade_auto = 1'b0;
    logic [FADE_W-1:0] fade_step = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    logic granted;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0] freed_count;
    logic [CNT_W-1:0] active_count;

    particle_pool_lifetime_manager_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .func         (func),
        .start_alpha  (start_alpha),
        .lifetime     (lifetime),
        .fade_auto    (fade_auto),
        .fade_step    (fade_step),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .granted      (granted),
        .slot         (slot),
        .freed_count  (freed_count),
        .active_count (active_count)
    );

    // predictor state: link memory, per-slot particle data, list heads
    logic [LINK_W-1:0]  nxt_link  [POOL_SIZE];
    logic [ALPHA_W-1:0] alpha_mem [POOL_SIZE];
    logic [FADE_W-1:0]  fade_mem  [POOL_SIZE];
    logic [LIFE_W-1:0]  life_mem  [POOL_SIZE];
    logic [LINK_W-1:0]  live_head;
    logic [LINK_W-1:0]  spare_head;
    int                 n_live;

    pool_req_t req_backlog[$];
    pool_rsp_t want_rsp[$];

    int  err_count = 0;
    int  idle_run = 0;
    int  cyc_count = 0;
    logic req_taken = 1'b0;
    logic calm_phase = 1'b0;
    bit  stim_calm = 1'b0;

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    function automatic pool_rsp_t pool_apply(logic f, logic [ALPHA_W-1:0] a,
                                             logic [LIFE_W-1:0] l, logic au,
                                             logic [FADE_W-1:0] st);
        pool_rsp_t r;
        int s, cur, prv, nx, freed, guard;
        logic [ALPHA_W-1:0] was, now;
        logic gone;
        r.granted = 1'b0;
        r.slot    = '0;
        r.freed   = '0;
        if (f == FUNC_SPAWN)
        begin
            s = int'(spare_head);
            if (s < POOL_SIZE)
            begin
                spare_head  = nxt_link[s];
                nxt_link[s] = live_head;
                live_head   = LINK_W'(s);
                n_live++;
                alpha_mem[s] = a;
                fade_mem[s]  = au ? FADE_W'(255 / ((l == '0) ? 1 : int'(l))) : st;
                life_mem[s]  = l;
                r.granted = 1'b1;
                r.slot    = s[SLOT_W-1:0];
            end
        end
        else
        begin
            cur   = int'(live_head);
            prv   = POOL_SIZE;
            freed = 0;
            guard = 0;
            while (cur < POOL_SIZE && guard < POOL_SIZE)
            begin
                nx  = int'(nxt_link[cur]);
                was = alpha_mem[cur];
                now = was - fade_mem[cur];
                guard++;
                alpha_mem[cur] = now;
                // an opacity wrap frees the slot before the lifetime is touched
                if (was < now)
                begin
                    gone = 1'b1;
                end
                else
                begin
                    life_mem[cur] = life_mem[cur] - 1'b1;
                    gone = (life_mem[cur] == '0);
                end
                if (gone)
                begin
                    alpha_mem[cur] = '0;
                    fade_mem[cur]  = '0;
                    life_mem[cur]  = '0;
                    if (prv < POOL_SIZE)
                        nxt_link[prv] = LINK_W'(nx);
                    else
                        live_head = LINK_W'(nx);
                    nxt_link[cur] = spare_head;
                    spare_head    = LINK_W'(cur);
                    freed++;
                    if (n_live > 0)
                        n_live--;
                end
                else
                begin
                    prv = cur;
                end
                cur = nx;
            end
            r.freed = freed[CNT_W-1:0];
        end
        r.live = n_live[CNT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch %s: got %0d want %0d", $realtime, what, got, want);
        err_count++;
    endtask

    task automatic queue_req(input logic f, input int a, input int l, input logic au,
                             input int st, input bit drain = 1'b0);
        pool_req_t q;
        q.func      = f;
        q.alpha     = ALPHA_W'(a);
        q.life      = LIFE_W'(l);
        q.fade_auto = au;
        q.fade_step = FADE_W'(st);
        q.drain     = drain;
        q.calm      = stim_calm;
        req_backlog.push_back(q);
    endtask

    task automatic queue_tick(input bit drain = 1'b0);
        queue_req(FUNC_TICK, $urandom_range(0, 255), $urandom_range(0, 65535),
                  1'($urandom_range(0, 1)), $urandom_range(0, 255), drain);
    endtask

    // a spawn that is sure to be freed on its first tick
    task automatic queue_short_spawn();
        int a;
        case ($urandom_range(0, 2))
            0: queue_req(FUNC_SPAWN, $urandom_range(0, 255), 1, 1'b0, $urandom_range(0, 255));
            1:
            begin
                a = $urandom_range(0, 254);
                queue_req(FUNC_SPAWN, a, $urandom_range(0, 65535), 1'b0,
                          $urandom_range(a + 1, 255));
            end
            default: queue_req(FUNC_SPAWN, $urandom_range(0, 255), 1, 1'b1,
                               $urandom_range(0, 255));
        endcase
    endtask

    // response check, request accept and watchdog count
    always @(posedge clk)
    begin
        pool_rsp_t w;
        logic took_req, took_rsp;
        took_req = rst_n && req_valid && !req_stall;
        took_rsp = rst_n && rsp_valid && !rsp_stall;
        cyc_count <= cyc_count + 1;
        if (took_rsp)
        begin
            if (want_rsp.size() == 0)
            begin
                $display("[%0t] result with no request outstanding", $realtime);
                err_count++;
            end
            else
            begin
                w = want_rsp.pop_front();
                if (granted !== w.granted)
                    report_mismatch("granted", 32'(granted), 32'(w.granted));
                if (slot !== w.slot)
                    report_mismatch("slot", 32'(slot), 32'(w.slot));
                if (freed_count !== w.freed)
                    report_mismatch("freed_count", 32'(freed_count), 32'(w.freed));
                if (active_count !== w.live)
                    report_mismatch("active_count", 32'(active_count), 32'(w.live));
            end
        end
        if (took_req)
            want_rsp.push_back(pool_apply(func, start_alpha, lifetime, fade_auto, fade_step));
        req_taken <= took_req;
        if (!rst_n || took_req || took_rsp)
            idle_run <= 0;
        else
            idle_run <= idle_run + 1;
    end

    // request driver
    always @(negedge clk)
    begin
        pool_req_t q;
        static int gap_left = 0;
        bit quiet_win;
        quiet_win = (cyc_count % 320) < 80;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else if (req_valid && !req_taken)
        begin
            // stalled: hold the request as it is
        end
        else if (gap_left > 0)
        begin
            req_valid <= 1'b0;
            gap_left--;
        end
        else if (req_backlog.size() == 0)
        begin
            req_valid <= 1'b0;
        end
        else if (req_backlog[0].drain && want_rsp.size() != 0)
        begin
            req_valid <= 1'b0;
        end
        else if (!req_backlog[0].calm && !quiet_win && $urandom_range(0, 7) == 0)
        begin
            gap_left = $urandom_range(1, 14) - 1;
            req_valid <= 1'b0;
        end
        else
        begin
            q = req_backlog.pop_front();
            func        <= q.func;
            start_alpha <= q.alpha;
            lifetime    <= q.life;
            fade_auto   <= q.fade_auto;
            fade_step   <= q.fade_step;
            calm_phase  <= q.calm;
            req_valid   <= 1'b1;
        end
    end

    // result-side backpressure
    always @(negedge clk)
    begin
        static int hold_left = 0;
        bit quiet_win;
        quiet_win = ((cyc_count + 160) % 320) < 80;
        if (hold_left > 0)
        begin
            rsp_stall <= 1'b1;
            hold_left--;
        end
        else if (!calm_phase && !quiet_win && $urandom_range(0, 7) == 0)
        begin
            hold_left = $urandom_range(1, 14) - 1;
            rsp_stall <= 1'b1;
        end
        else
        begin
            rsp_stall <= 1'b0;
        end
    end

    initial
    begin
        wait (idle_run >= WATCHDOG_LIMIT);
        $display("** particle_pool_lifetime_manager_unit: FAILED **");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            nxt_link[i]  = LINK_W'(i + 1);
            alpha_mem[i] = '0;
            fade_mem[i]  = '0;
            life_mem[i]  = '0;
        end
        live_head  = LINK_NULL;
        spare_head = '0;
        n_live     = 0;

        // directed part
        queue_tick();                                   // tick on an empty list
        queue_req(FUNC_SPAWN, 255, 65535, 1'b1, 0);     // auto fade 0, lives on
        queue_req(FUNC_SPAWN, 0, 1, 1'b0, 0);           // lifetime runs out
        queue_req(FUNC_SPAWN, 10, 5, 1'b0, 20);         // opacity wraps first
        queue_req(FUNC_SPAWN, 200, 0, 1'b1, 0);         // zero life, auto fade 255
        queue_req(FUNC_SPAWN, 255, 0, 1'b0, 0);         // zero life wraps to 65535
        queue_req(FUNC_SPAWN, 128, 3, 1'b1, 0);         // fade 85
        queue_req(FUNC_SPAWN, 255, 255, 1'b1, 0);       // fade 1
        queue_req(FUNC_SPAWN, 100, 256, 1'b1, 255);     // fade 0
        queue_req(FUNC_TICK, 255, 65535, 1'b1, 255);    // spawn fields ignored
        queue_req(FUNC_TICK, 0, 0, 1'b0, 0);
        queue_req(FUNC_SPAWN, 0, 2, 1'b0, 255);
        queue_req(FUNC_SPAWN, 255, 1, 1'b1, 0);         // reaches zero exactly, no wrap
        queue_tick(1'b1);
        queue_req(FUNC_SPAWN, 255, 16'h8000, 1'b0, 8'h80);
        queue_req(FUNC_SPAWN, 0, 16'h7fff, 1'b1, 8'h7f);
        repeat (3) queue_tick();

        // random part
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            int l, st;
            if ($urandom_range(0, 99) < 55)
            begin
                case ($urandom_range(0, 4))
                    0, 1, 2: l = $urandom_range(1, 12);
                    3:       l = $urandom_range(0, 300);
                    default: l = $urandom_range(0, 65535);
                endcase
                st = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 40) : $urandom_range(0, 255);
                queue_req(FUNC_SPAWN, $urandom_range(0, 255), l, 1'($urandom_range(0, 1)), st);
            end
            else
            begin
                queue_tick(i == 55);
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // wait for the random part to settle, then finish with no idling
        while (req_backlog.size() != 0 || req_valid || want_rsp.size() != 0)
            @(posedge clk);
        stim_calm = 1'b1;
        for (int i = 0; i < TAIL_SPAWNS; i++)
            queue_short_spawn();
        queue_tick();
        queue_tick();
        queue_req(FUNC_SPAWN, 77, 4, 1'b1, 0);
        queue_tick();

        while (req_backlog.size() != 0 || req_valid || want_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("** particle_pool_lifetime_manager_unit: PASSED **");
        else
            $display("** particle_pool_lifetime_manager_unit: FAILED **");
        $finish;
    end

endmodule
